@@ rtl/call_stack_profiler_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the call stack profiler
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CALL_STACK_PROFILER_MACROS_SVH
`define CALL_STACK_PROFILER_MACROS_SVH

`ifndef SYNTH
`define CSP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define CSP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSP_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define CSP_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/csp_pkg.sv @@
// ----------------------------------------------------------------------------
// csp_pkg
// Types and constants shared by the call stack profiler modules.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int STACK_DEPTH_DEF  = 2048;
    localparam int FUNC_ENTRIES_DEF = 1024;
    localparam int LEVEL_W          = 16;
    localparam int FID_W            = 10;
    localparam int SMP_W            = 63;
    localparam int VAL_W            = 64;
    localparam int CNT_W            = 32;
    localparam int REC_W            = 12;
    localparam int LIMIT_W          = 12;
    localparam int IN_DATA_W        = 80;
    localparam int OUT_DATA_W       = 336;

    typedef enum logic [2:0] {
        REQ_ENTER    = 3'd0,
        REQ_EXIT     = 3'd1,
        REQ_UNWIND   = 3'd2,
        REQ_FINALIZE = 3'd3,
        REQ_READ     = 3'd4
    } req_e_t;

    typedef enum logic [1:0] {
        EV_START    = 2'd0,
        EV_END      = 2'd1,
        EV_FINALIZE = 2'd2,
        EV_READOUT  = 2'd3
    } event_e_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ENT_WAIT,
        S_RD_WAIT,
        S_X_LOAD,
        S_X_EXC,
        S_WALK,
        S_STAT,
        S_STAT_UPD,
        S_EMIT
    } state_e_t;

    typedef struct packed {
        logic [CNT_W-1:0] calls;
        logic [REC_W-1:0] max_rec;
        logic [VAL_W-1:0] incl;
        logic [VAL_W-1:0] excl;
    } stat_t;

    localparam int STAT_W = $bits(stat_t);

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [LEVEL_W-1:0] stack_level;
        logic               has_caller;
        logic [FID_W-1:0]   caller_id;
        logic [FID_W-1:0]   callee_id;
        logic [VAL_W-1:0]   inclusive;
        logic [VAL_W-1:0]   exclusive;
        logic [CNT_W-1:0]   call_total;
        logic [VAL_W-1:0]   cumulative;
        logic [SMP_W-1:0]   peak;
        logic [REC_W-1:0]   recursion_depth;
    } result_t;

endpackage

@@ rtl/call_stack_profiler.sv @@
// ----------------------------------------------------------------------------
// call_stack_profiler
// Inclusive and exclusive call profiler with a frame stack and per-function
// statistics for one metric.
// ----------------------------------------------------------------------------
// One item is handled at a time by a small sequencer around its adders and
// the frame and statistics memories. An enter reads the caller's id when the
// stack is not empty; a profiled exit loads the frame left, forms its
// exclusive value, walks the frames below it and then updates the statistics;
// the recursion walk reads one frame per cycle through the single read port of
// the frame memory. Ignored requests return to idle with no result. After
// reset a clearing pass zeroes the statistics memory before the first item is
// taken; configuration writes are taken during it. A finished result waits in
// an output register, and the next item is taken while it waits.
module call_stack_profiler
    import csp_pkg::*;
#(
    parameter int STACK_DEPTH  = csp_pkg::STACK_DEPTH_DEF,
    parameter int FUNC_ENTRIES = csp_pkg::FUNC_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [csp_pkg::LIMIT_W-1:0]       cfg_wr_data,  // depth_limit
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func_id [9:0], metric_sample [72:10], zero fill [79:73]
    input  logic [csp_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [2:0]                        s_tuser,      // req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // stack_level, has_caller, caller_id, callee_id, inclusive, exclusive,
    // call_total, cumulative, peak, recursion_depth
    output logic [csp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [1:0]                        m_tuser       // event_kind
);

    `include "call_stack_profiler_macros.svh"

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int FAW = $clog2(FUNC_ENTRIES);
    localparam logic [LEVEL_W:0] SD_EXT = (LEVEL_W+1)'(STACK_DEPTH);
    localparam logic [LEVEL_W:0] FE_EXT = (LEVEL_W+1)'(FUNC_ENTRIES);
    localparam logic [FAW-1:0]   CLR_LAST = FAW'(FUNC_ENTRIES - 1);
    localparam logic [REC_W-1:0] REC_MAX = '1;

    state_e_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               active_reg, active_next;
    logic               fin_reg, fin_next;
    logic [CNT_W-1:0]   ec_reg, ec_next;
    logic [SMP_W-1:0]   first_reg, first_next;
    logic [SMP_W-1:0]   latest_reg, latest_next;
    logic [SMP_W-1:0]   peak_reg, peak_next;

    req_e_t             req_reg;
    logic [FID_W-1:0]   fid_reg;
    logic [SMP_W-1:0]   smp_reg;

    logic [SAW-1:0]     d_reg, d_next;
    logic [SAW-1:0]     k_reg, k_next;
    logic [FID_W-1:0]   f_reg, f_next;
    logic [VAL_W-1:0]   inc_reg, inc_next;
    logic [VAL_W-1:0]   exc_reg, exc_next;
    logic [VAL_W-1:0]   chd_reg, chd_next;
    logic [REC_W-1:0]   cyc_reg, cyc_next;
    logic [FAW-1:0]     clr_reg, clr_next;
    result_t            w_reg, w_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg;
    logic               out_free;

    // Frame and statistics memory ports.
    logic               func_we, start_we, chd_we;
    logic [SAW-1:0]     fr_waddr, fr_raddr;
    logic [FID_W-1:0]   func_wdata, func_rdata;
    logic [SMP_W-1:0]   start_wdata, start_rdata;
    logic [VAL_W-1:0]   chd_wdata, chd_rdata;
    logic               st_we;
    logic [FAW-1:0]     st_waddr, st_raddr;
    stat_t              st_wdata, st_rdata;

    // Decode helpers.
    logic [LEVEL_W:0]   lim_eff;
    logic [LEVEL_W-1:0] lvl_m1;
    logic               active_eff;
    logic               is_parent, match, first_hit;
    logic [VAL_W-1:0]   delta;
    logic               f_known;

    csp_ram #(.WIDTH(FID_W), .DEPTH(STACK_DEPTH)) u_func_ram (
        .aclk(aclk), .we(func_we), .waddr(fr_waddr), .wdata(func_wdata),
        .raddr(fr_raddr), .rdata(func_rdata)
    );
    csp_ram #(.WIDTH(SMP_W), .DEPTH(STACK_DEPTH)) u_start_ram (
        .aclk(aclk), .we(start_we), .waddr(fr_waddr), .wdata(start_wdata),
        .raddr(fr_raddr), .rdata(start_rdata)
    );
    csp_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_chd_ram (
        .aclk(aclk), .we(chd_we), .waddr(fr_waddr), .wdata(chd_wdata),
        .raddr(fr_raddr), .rdata(chd_rdata)
    );
    csp_ram #(.WIDTH(STAT_W), .DEPTH(FUNC_ENTRIES)) u_stat_ram (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {out_reg.recursion_depth, out_reg.peak, out_reg.cumulative,
                       out_reg.call_total, out_reg.exclusive, out_reg.inclusive,
                       out_reg.callee_id, out_reg.caller_id, out_reg.has_caller,
                       out_reg.stack_level};
    assign out_free = !out_valid_reg || m_tready;

    // A limit of zero, or one at or past the stack size, means the whole stack.
    assign lim_eff = (limit_reg == '0 || (LEVEL_W+1)'(limit_reg) >= SD_EXT) ?
                     SD_EXT : (LEVEL_W+1)'(limit_reg);
    assign lvl_m1     = level_reg - 1'b1;
    assign active_eff = (req_reg == REQ_UNWIND) ? 1'b1 : active_reg;
    assign is_parent  = (k_reg == d_reg - 1'b1);
    assign match      = (func_rdata == f_reg);
    assign first_hit  = match && (cyc_reg == '0);
    assign f_known    = ((LEVEL_W+1)'(f_reg) < FE_EXT);

    // The parent gains inc, the innermost recursive ancestor loses exc; when
    // both are the same frame the net change is inc - exc, the child's sum.
    always_comb begin
        if (is_parent && first_hit) begin
            delta = chd_reg;
        end else if (is_parent) begin
            delta = inc_reg;
        end else begin
            delta = '0 - exc_reg;
        end
    end

    // The result picks up the level and the sample summary as it leaves.
    always_comb begin
        out_next             = w_reg;
        out_next.stack_level = level_reg;
        out_next.cumulative  = VAL_W'(latest_reg) - VAL_W'(first_reg);
        out_next.peak        = peak_reg;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                state_next = S_IDLE;
                priority case (req_reg)
                    REQ_FINALIZE: state_next = S_EMIT;
                    REQ_READ: begin
                        state_next = ((LEVEL_W+1)'(fid_reg) < FE_EXT) ? S_RD_WAIT : S_EMIT;
                    end
                    REQ_ENTER: begin
                        if (!fin_reg && {1'b0, level_reg} < lim_eff) begin
                            state_next = (level_reg != '0) ? S_ENT_WAIT : S_EMIT;
                        end
                    end
                    REQ_EXIT, REQ_UNWIND: begin
                        if (!fin_reg && level_reg != '0 && active_eff &&
                            {1'b0, lvl_m1} < SD_EXT) begin
                            state_next = S_X_LOAD;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_ENT_WAIT: state_next = S_EMIT;
            S_RD_WAIT:  state_next = S_EMIT;
            S_X_LOAD:   state_next = S_X_EXC;
            S_X_EXC:    state_next = (d_reg != '0) ? S_WALK : S_STAT;
            S_WALK: begin
                if (k_reg == '0) state_next = S_STAT;
            end
            S_STAT:     state_next = f_known ? S_STAT_UPD : S_EMIT;
            S_STAT_UPD: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        level_next  = level_reg;
        active_next = active_reg;
        fin_next    = fin_reg;
        ec_next     = ec_reg;
        first_next  = first_reg;
        latest_next = latest_reg;
        peak_next   = peak_reg;
        d_next      = d_reg;
        k_next      = k_reg;
        f_next      = f_reg;
        inc_next    = inc_reg;
        exc_next    = exc_reg;
        chd_next    = chd_reg;
        cyc_next    = cyc_reg;
        clr_next    = clr_reg;
        w_next      = w_reg;
        func_we     = 1'b0;
        start_we    = 1'b0;
        chd_we      = 1'b0;
        fr_waddr    = SAW'(level_reg);
        fr_raddr    = d_reg;
        func_wdata  = fid_reg;
        start_wdata = smp_reg;
        chd_wdata   = '0;
        st_we       = 1'b0;
        st_waddr    = FAW'(f_reg);
        st_raddr    = FAW'(f_reg);
        st_wdata    = '0;

        unique case (state_reg)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            S_DECODE: begin
                w_next            = '0;
                w_next.callee_id  = fid_reg;
                w_next.call_total = ec_reg;
                priority case (req_reg)
                    REQ_FINALIZE: begin
                        active_next       = 1'b1;
                        level_next        = '0;
                        fin_next          = 1'b1;
                        w_next.event_kind = EV_FINALIZE;
                        w_next.callee_id  = '0;
                    end
                    REQ_READ: begin
                        st_raddr          = FAW'(fid_reg);
                        w_next.event_kind = EV_READOUT;
                        w_next.call_total = '0;
                    end
                    REQ_ENTER: begin
                        if (!fin_reg) begin
                            if ({1'b0, level_reg} >= lim_eff) begin
                                active_next = 1'b0;
                                if (level_reg != '1) level_next = level_reg + 1'b1;
                            end else begin
                                active_next = 1'b1;
                                latest_next = smp_reg;
                                if (ec_reg == '0) begin
                                    first_next = smp_reg;
                                    peak_next  = smp_reg;
                                end else if (smp_reg > peak_reg) begin
                                    peak_next  = smp_reg;
                                end
                                ec_next           = ec_reg + 1'b1;
                                func_we           = 1'b1;
                                start_we          = 1'b1;
                                chd_we            = 1'b1;
                                fr_raddr          = SAW'(lvl_m1);
                                if (level_reg != '1) level_next = level_reg + 1'b1;
                                w_next.event_kind = EV_START;
                                w_next.has_caller = (level_reg != '0);
                                w_next.call_total = ec_reg + 1'b1;
                            end
                        end
                    end
                    REQ_EXIT, REQ_UNWIND: begin
                        if (!fin_reg) begin
                            active_next = active_eff;
                            if (level_reg != '0) begin
                                level_next = lvl_m1;
                                if (active_eff && {1'b0, lvl_m1} < SD_EXT) begin
                                    latest_next = smp_reg;
                                    if (smp_reg > peak_reg) peak_next = smp_reg;
                                    d_next   = SAW'(lvl_m1);
                                    fr_raddr = SAW'(lvl_m1);
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_ENT_WAIT: begin
                w_next.caller_id = func_rdata;
            end
            S_RD_WAIT: begin
                w_next.inclusive       = st_rdata.incl;
                w_next.exclusive       = st_rdata.excl;
                w_next.call_total      = st_rdata.calls;
                w_next.recursion_depth = st_rdata.max_rec;
            end
            S_X_LOAD: begin
                f_next   = func_rdata;
                inc_next = VAL_W'(smp_reg) - VAL_W'(start_rdata);
                chd_next = chd_rdata;
            end
            S_X_EXC: begin
                exc_next          = inc_reg - chd_reg;
                cyc_next          = '0;
                k_next            = d_reg - 1'b1;
                fr_raddr          = d_reg - 1'b1;
                w_next.event_kind = EV_END;
                w_next.has_caller = (d_reg != '0);
                w_next.callee_id  = f_reg;
                w_next.inclusive  = inc_reg;
                w_next.exclusive  = inc_reg - chd_reg;
            end
            S_WALK: begin
                fr_raddr  = k_reg - 1'b1;
                fr_waddr  = k_reg;
                chd_wdata = chd_rdata + delta;
                chd_we    = is_parent || first_hit;
                if (is_parent) w_next.caller_id = func_rdata;
                if (match && cyc_reg != REC_MAX) cyc_next = cyc_reg + 1'b1;
                k_next = k_reg - 1'b1;
            end
            S_STAT: begin
                w_next.recursion_depth = cyc_reg;
            end
            S_STAT_UPD: begin
                st_we          = 1'b1;
                st_wdata.calls = st_rdata.calls + 1'b1;
                st_wdata.max_rec = (st_rdata.max_rec < cyc_reg) ? cyc_reg : st_rdata.max_rec;
                if (cyc_reg == '0) begin
                    st_wdata.incl = st_rdata.incl + inc_reg;
                    st_wdata.excl = st_rdata.excl + exc_reg;
                end else begin
                    st_wdata.incl = st_rdata.incl;
                    st_wdata.excl = st_rdata.excl;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            limit_reg     <= LIMIT_W'(STACK_DEPTH_DEF);
            level_reg     <= '0;
            active_reg    <= 1'b1;
            fin_reg       <= 1'b0;
            ec_reg        <= '0;
            first_reg     <= '0;
            latest_reg    <= '0;
            peak_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            active_reg <= active_next;
            fin_reg    <= fin_next;
            ec_reg     <= ec_next;
            first_reg  <= first_next;
            latest_reg <= latest_next;
            peak_reg   <= peak_next;
            clr_reg    <= clr_next;
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
            if (state_reg == S_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= req_e_t'(s_tuser);
            fid_reg <= s_tdata[FID_W-1:0];
            smp_reg <= s_tdata[FID_W+SMP_W-1:FID_W];
        end
        d_reg   <= d_next;
        k_reg   <= k_next;
        f_reg   <= f_next;
        inc_reg <= inc_next;
        exc_reg <= exc_next;
        chd_reg <= chd_next;
        cyc_reg <= cyc_next;
        w_reg   <= w_next;
        if (state_reg == S_EMIT && out_free) begin
            out_reg <= out_next;
        end
    end

    `CSP_ASSERT_IMP(a_walk_below_exit, aclk, aresetn, state_reg == S_WALK, k_reg < d_reg, "walk index not below exited frame")
    `CSP_ASSERT_IMP(a_rec_bounded, aclk, aresetn, state_reg == S_STAT, LEVEL_W'(cyc_reg) <= LEVEL_W'(d_reg), "recursion count exceeds frames walked")
    `CSP_ASSERT_NXT(a_emit_loads, aclk, aresetn, state_reg == S_EMIT && out_free, m_tvalid && state_reg == S_IDLE, "result not presented after emit")
    `CSP_ASSERT_IMP(a_no_take_in_clear, aclk, aresetn, state_reg == S_CLEAR, !s_tready && !out_valid_reg, "item or result during clearing pass")

endmodule

@@ rtl/csp_ram.sv @@
// ----------------------------------------------------------------------------
// csp_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module csp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
